// ===== rtl/glos_pkg.sv =====
`timescale 1ns / 1ps

package glos_pkg;

  typedef logic [7:0] coord_t;
  typedef logic [2:0] terrain_t;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam terrain_t TERRAIN_OPEN     = 3'd0;
  localparam terrain_t TERRAIN_OBSTACLE = 3'd5;

  localparam logic [8:0] GRID_DIM_RESET = 9'd256;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] command;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     end_x;
    coord_t     end_y;
    terrain_t   new_terrain;
  } glos_req_t;

  typedef struct packed {
    logic     in_bounds;
    terrain_t cell_terrain;
    logic     cell_passable;
    logic     line_clear;
  } glos_rsp_t;

  typedef struct packed {
    logic load;
    logic advance;
  } glos_step_ctrl_t;

endpackage

// ===== rtl/glos_grid_mem.sv =====
`timescale 1ns / 1ps

module glos_grid_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  glos_pkg::terrain_t       wdata,
  input  logic [AW-1:0]            raddr,
  output glos_pkg::terrain_t       rdata
);

  glos_pkg::terrain_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/glos_stepper.sv =====
`timescale 1ns / 1ps

module glos_stepper (
  input  logic                      clk,
  input  logic                      rst,
  input  glos_pkg::glos_step_ctrl_t ctrl,
  input  glos_pkg::coord_t          start_x,
  input  glos_pkg::coord_t          start_y,
  input  glos_pkg::coord_t          end_x,
  input  glos_pkg::coord_t          end_y,
  output glos_pkg::coord_t          pos_x,
  output glos_pkg::coord_t          pos_y,
  output glos_pkg::coord_t          pos_x_next,
  output glos_pkg::coord_t          pos_y_next,
  output logic                      at_end
);

  glos_pkg::coord_t   tgt_x;
  glos_pkg::coord_t   tgt_y;
  logic [7:0]         dx;
  logic [7:0]         dy;
  logic               neg_x;
  logic               neg_y;
  logic signed [10:0] walk_error;
  logic signed [10:0] walk_error_next;

  logic [7:0]         dx_load;
  logic [7:0]         dy_load;
  logic signed [11:0] e2;
  logic               move_x;
  logic               move_y;

  always_comb begin
    dx_load = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    dy_load = (start_y > end_y) ? start_y - end_y : end_y - start_y;

    // shared error update
    e2     = {walk_error, 1'b0};
    move_x = e2 > -$signed({4'b0, dy});
    move_y = e2 < $signed({4'b0, dx});
    walk_error_next = walk_error
                    - (move_x ? $signed({3'b0, dy}) : 11'sd0)
                    + (move_y ? $signed({3'b0, dx}) : 11'sd0);

    pos_x_next = pos_x;
    if (move_x) begin
      pos_x_next = neg_x ? pos_x - 8'd1 : pos_x + 8'd1;
    end
    pos_y_next = pos_y;
    if (move_y) begin
      pos_y_next = neg_y ? pos_y - 8'd1 : pos_y + 8'd1;
    end

    at_end = (pos_x == tgt_x) && (pos_y == tgt_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_error <= '0;
    end else if (ctrl.load) begin
      walk_error <= $signed({3'b0, dx_load}) - $signed({3'b0, dy_load});
    end else if (ctrl.advance) begin
      walk_error <= walk_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos_x <= start_x;
      pos_y <= start_y;
      tgt_x <= end_x;
      tgt_y <= end_y;
      dx    <= dx_load;
      dy    <= dy_load;
      neg_x <= !(start_x < end_x);
      neg_y <= !(start_y < end_y);
    end else if (ctrl.advance) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
    end
  end

endmodule

// ===== rtl/grid_line_of_sight_checker_core.sv =====
`timescale 1ns / 1ps

// Terrain grid with cell write, cell read and Bresenham line-of-sight query.
// After reset the block holds busy while it clears every cell of the grid
// memory to open terrain, one cell per cycle; register writes are taken during
// that pass. A write, or an unused command, is accepted with busy staying low,
// and its result appears on the next cycle. A read holds busy in the read
// state, and its result is registered as it leaves that state. A line query
// holds busy while it walks the cells from start to end, and stops early at
// a blocked cell: the walk advances one cell per cycle, bounded by the single
// read port of the grid memory, and the result appears in the first cycle
// with busy low. Each result is shown for exactly one cycle with done high;
// there is no back-pressure on results.
module grid_line_of_sight_checker_core #(
  parameter int MAX_DIM = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  glos_pkg::glos_req_t   request,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  glos_pkg::cfg_idx_t    cfg_index,
  input  logic [8:0]            cfg_data,
  output logic                  done,
  output glos_pkg::glos_rsp_t   result
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_DIM);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [12:0]   DIM_LIMIT  = 13'(MAX_DIM);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [AW-1:0]             clr_cnt;
  logic [8:0]                grid_width;
  logic [8:0]                grid_height;
  glos_pkg::glos_req_t       req_q;
  logic                      inb_q;
  logic                      chk_valid;
  logic                      chk_skip;
  logic                      chk_inside;

  logic                      accept;
  logic                      req_inside;
  logic                      end_inside;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  glos_pkg::terrain_t        mem_wdata;
  logic [AW-1:0]             mem_raddr;
  glos_pkg::terrain_t        mem_rdata;
  glos_pkg::glos_step_ctrl_t step_ctrl;
  glos_pkg::coord_t          pos_x;
  glos_pkg::coord_t          pos_y;
  glos_pkg::coord_t          pos_x_next;
  glos_pkg::coord_t          pos_y_next;
  logic                      at_end;
  logic                      blocked;
  logic                      new_skip;
  logic                      new_inside;
  logic                      result_load;
  glos_pkg::glos_rsp_t       result_next;

  function automatic logic cell_inside(glos_pkg::coord_t x, glos_pkg::coord_t y,
                                       logic [8:0] w, logic [8:0] h);
    return ({1'b0, x} < w) && ({5'b0, x} < DIM_LIMIT)
        && ({1'b0, y} < h) && ({5'b0, y} < DIM_LIMIT);
  endfunction

  function automatic logic [AW-1:0] cell_addr(glos_pkg::coord_t x, glos_pkg::coord_t y);
    return AW'(y) * ROW_STRIDE + AW'(x);
  endfunction

  glos_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  glos_stepper u_step (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (step_ctrl),
    .start_x    (request.start_x),
    .start_y    (request.start_y),
    .end_x      (request.end_x),
    .end_y      (request.end_y),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_x_next (pos_x_next),
    .pos_y_next (pos_y_next),
    .at_end     (at_end)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    req_inside = cell_inside(request.start_x, request.start_y, grid_width, grid_height);
    end_inside = cell_inside(request.end_x, request.end_y, grid_width, grid_height);

    mem_we    = 1'b0;
    mem_waddr = cell_addr(request.start_x, request.start_y);
    mem_wdata = (request.new_terrain > glos_pkg::TERRAIN_OBSTACLE)
              ? glos_pkg::TERRAIN_OBSTACLE : request.new_terrain;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = glos_pkg::TERRAIN_OPEN;
    end else if (accept && request.command == glos_pkg::CMD_WRITE && req_inside) begin
      mem_we = 1'b1;
    end

    mem_raddr = (state == S_IDLE) ? cell_addr(request.start_x, request.start_y)
                                  : cell_addr(pos_x_next, pos_y_next);

    blocked = chk_valid && !chk_skip
           && (!chk_inside || mem_rdata == glos_pkg::TERRAIN_OBSTACLE);
    new_skip = ((pos_x_next == req_q.start_x) && (pos_y_next == req_q.start_y))
            || ((pos_x_next == req_q.end_x) && (pos_y_next == req_q.end_y));
    new_inside = cell_inside(pos_x_next, pos_y_next, grid_width, grid_height);

    step_ctrl.load    = accept && request.command == glos_pkg::CMD_QUERY;
    step_ctrl.advance = (state == S_WALK) && !blocked && !at_end;

    state_next  = state;
    result_load = 1'b0;
    result_next = '0;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (request.command)
            glos_pkg::CMD_WRITE: begin
              result_load           = 1'b1;
              result_next.in_bounds = req_inside;
            end
            glos_pkg::CMD_READ: begin
              state_next = S_READ;
            end
            glos_pkg::CMD_QUERY: begin
              state_next = S_WALK;
            end
            default: begin
              result_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        state_next                = S_IDLE;
        result_load               = 1'b1;
        result_next.in_bounds     = inb_q;
        result_next.cell_terrain  = inb_q ? mem_rdata : glos_pkg::TERRAIN_OBSTACLE;
        result_next.cell_passable = inb_q && (mem_rdata != glos_pkg::TERRAIN_OBSTACLE);
      end
      S_WALK: begin
        if (blocked || at_end) begin
          state_next             = S_IDLE;
          result_load            = 1'b1;
          result_next.in_bounds  = inb_q;
          result_next.line_clear = !blocked;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      grid_width  <= glos_pkg::GRID_DIM_RESET;
      grid_height <= glos_pkg::GRID_DIM_RESET;
      done        <= 1'b0;
      chk_valid   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= result_load;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (step_ctrl.load) begin
        chk_valid <= 1'b0;
      end else if (step_ctrl.advance) begin
        chk_valid <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          glos_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          glos_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
      inb_q <= (request.command == glos_pkg::CMD_QUERY) ? (req_inside && end_inside)
                                                         : req_inside;
    end
    if (step_ctrl.advance) begin
      chk_skip   <= new_skip;
      chk_inside <= new_inside;
    end
    if (result_load) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/glos_checker.sv =====
`timescale 1ns / 1ps

module glos_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input glos_pkg::glos_req_t request,
  input logic                done,
  input glos_pkg::glos_rsp_t result
);

  // clearing pass keeps requests out right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command == glos_pkg::CMD_WRITE
                        || request.command == glos_pkg::CMD_UNUSED))
    |=> done)
    else $error("write request without result on next cycle");

  a_read_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == glos_pkg::CMD_READ) |=> busy ##1 done)
    else $error("read request timing broken");

  a_passable_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (done && result.cell_passable)
    |-> (result.in_bounds && result.cell_terrain != glos_pkg::TERRAIN_OBSTACLE))
    else $error("passable cell out of bounds or obstacle");

  a_clear_no_cell: assert property (@(posedge clk) disable iff (rst)
    (done && result.line_clear)
    |-> (!result.cell_passable && result.cell_terrain == glos_pkg::TERRAIN_OPEN))
    else $error("query result carries cell fields");

endmodule

bind grid_line_of_sight_checker_core glos_checker u_glos_checker (.*);
